// ===== hw/rtl/rmq_pkg.sv =====
// Shared types, constants and helpers for the rotation matrix to quaternion block.
`timescale 1ns / 1ps
`default_nettype none
package rmq_pkg;

    localparam int FRAC_BITS_DEF = 30;   // fraction bits of the fixed-point format
    localparam int DATA_W        = 32;   // width of every matrix entry and quaternion field
    localparam int NUM_W         = 33;   // signed sum or difference of two entries
    localparam int QUOT_W        = 33;   // quotient bits kept before saturation
    localparam int EPS_W         = 31;
    localparam int QUEUE_DEPTH   = 2;
    localparam logic [EPS_W-1:0] EPS_RESET = 31'd1074;
    localparam logic [DATA_W-1:0] Q_MAX = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] Q_MIN = 32'h8000_0000;

    typedef enum logic [1:0] {
        BR_TRACE = 2'd0,
        BR_X     = 2'd1,
        BR_Y     = 2'd2,
        BR_Z     = 2'd3
    } branch_t;

    // Three quotient slots: the non-dominant components in x, y, z, w order.
    typedef struct packed {
        branch_t                    branch;
        logic                       bad;
        logic [2:0]                 num_neg;
        logic [2:0][NUM_W-1:0]      num_mag;
    } meta_t;

    // Sum or difference of two entries, returned as {sign, magnitude}.
    function automatic logic [NUM_W:0] num_term(input logic signed [DATA_W-1:0] a,
                                                input logic signed [DATA_W-1:0] b,
                                                input logic sub);
        logic signed [NUM_W-1:0] v;
        logic [NUM_W-1:0] mag;
        v = sub ? (NUM_W'(a) - NUM_W'(b)) : (NUM_W'(a) + NUM_W'(b));
        mag = v[NUM_W-1] ? NUM_W'(-v) : NUM_W'(v);
        return {v[NUM_W-1], mag};
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/rmq_front.sv =====
// Front end: accepts a matrix, picks the branch, forms radicand and numerators.
`timescale 1ns / 1ps
`default_nettype none
module rmq_front #(
    parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF,
    parameter int RAD_W     = 34
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [9*rmq_pkg::DATA_W-1:0]  s_tdata,
    input  wire logic [rmq_pkg::EPS_W-1:0]     epsilon,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output rmq_pkg::meta_t                     out_meta,
    output logic [RAD_W-1:0]                   out_rad
);
    import rmq_pkg::*;

    localparam int SUM_W = RAD_W + 1;
    localparam logic signed [SUM_W-1:0] ONE =
        {{(SUM_W-FRAC_BITS-1){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};

    logic signed [DATA_W-1:0] a00, a01, a02, a10, a11, a12, a20, a21, a22;
    logic signed [SUM_W-1:0]  e00, e11, e22, t, rad, eps_ext;
    branch_t                  branch;
    logic [NUM_W:0]           d12, d20, d01, p01, p20, p12;
    meta_t                    meta_next;
    logic [RAD_W-1:0]         rad_next;
    logic                     valid_reg;
    meta_t                    meta_reg;
    logic [RAD_W-1:0]         rad_reg;

    assign a00 = s_tdata[0*DATA_W +: DATA_W];
    assign a01 = s_tdata[1*DATA_W +: DATA_W];
    assign a02 = s_tdata[2*DATA_W +: DATA_W];
    assign a10 = s_tdata[3*DATA_W +: DATA_W];
    assign a11 = s_tdata[4*DATA_W +: DATA_W];
    assign a12 = s_tdata[5*DATA_W +: DATA_W];
    assign a20 = s_tdata[6*DATA_W +: DATA_W];
    assign a21 = s_tdata[7*DATA_W +: DATA_W];
    assign a22 = s_tdata[8*DATA_W +: DATA_W];

    assign e00 = SUM_W'(a00);
    assign e11 = SUM_W'(a11);
    assign e22 = SUM_W'(a22);
    assign t       = ONE + e00 + e11 + e22;
    assign eps_ext = $signed(SUM_W'(epsilon));

    assign d12 = num_term(a12, a21, 1'b1);
    assign d20 = num_term(a20, a02, 1'b1);
    assign d01 = num_term(a01, a10, 1'b1);
    assign p01 = num_term(a01, a10, 1'b0);
    assign p20 = num_term(a20, a02, 1'b0);
    assign p12 = num_term(a12, a21, 1'b0);

    always_comb begin
        if (t > eps_ext) begin
            branch = BR_TRACE;
            rad    = t;
        end else if (a00 > a11 && a00 > a22) begin
            branch = BR_X;
            rad    = ONE + e00 - e11 - e22;
        end else if (a11 > a22) begin
            branch = BR_Y;
            rad    = ONE + e11 - e00 - e22;
        end else begin
            branch = BR_Z;
            rad    = ONE + e22 - e00 - e11;
        end
    end

    always_comb begin
        logic [2:0][NUM_W:0] slot;
        unique case (branch)
            BR_TRACE: slot = {d01, d20, d12};
            BR_X:     slot = {d12, p20, p01};
            BR_Y:     slot = {d20, p12, p01};
            BR_Z:     slot = {d01, p12, p20};
            default:  slot = {d01, d20, d12};
        endcase
        meta_next.branch = branch;
        meta_next.bad    = rad[SUM_W-1] || (rad == '0);
        for (int i = 0; i < 3; i++) begin
            meta_next.num_neg[i] = slot[i][NUM_W];
            meta_next.num_mag[i] = slot[i][NUM_W-1:0];
        end
        rad_next = rad[RAD_W-1:0];
    end

    assign s_tready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_tready) begin
            valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            meta_reg <= meta_next;
            rad_reg  <= rad_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_meta  = meta_reg;
    assign out_rad   = rad_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/rmq_fifo.sv =====
// Short queue between the front end and the arithmetic back end.
`timescale 1ns / 1ps
`default_nettype none
module rmq_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = rmq_pkg::QUEUE_DEPTH
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic [WIDTH-1:0] in_data,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic [WIDTH-1:0]      out_data
);
    import rmq_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg, wr_ptr_next, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push, pop;

    assign in_ready  = (count_reg != CNT_W'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_data  = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/rmq_div.sv =====
// Pipelined restoring divider: (mag * 2^FRAC_BITS) / s, signed and saturated to 32 bits.
`timescale 1ns / 1ps
`default_nettype none
module rmq_div #(
    parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF,
    parameter int S_W       = 33
) (
    input  wire logic                          aclk,
    input  wire logic                          en,
    input  wire logic [rmq_pkg::NUM_W-1:0]     mag,
    input  wire logic                          neg,
    input  wire logic [S_W-1:0]                s,
    output logic [rmq_pkg::DATA_W-1:0]         q_out
);
    import rmq_pkg::*;

    localparam int D_W  = NUM_W + FRAC_BITS;
    localparam int P0_W = D_W - QUOT_W;
    localparam int C_W  = (P0_W > S_W) ? P0_W : S_W;
    localparam int NST  = QUOT_W + 1;

    logic [D_W-1:0]    dividend;
    logic [P0_W-1:0]   p0;
    logic              big0;

    logic [S_W-1:0]    p_reg   [NST];
    logic [QUOT_W-1:0] q_reg   [NST];
    logic [QUOT_W-1:0] dlo_reg [NST];
    logic [S_W-1:0]    s_reg   [NST];
    logic              neg_reg [NST];
    logic              big_reg [NST];

    assign dividend = {mag, {FRAC_BITS{1'b0}}};
    assign p0       = dividend[D_W-1:QUOT_W];
    // Quotient would need more than QUOT_W bits: saturates regardless.
    assign big0     = (C_W'(p0) >= C_W'(s));

    always_ff @(posedge aclk) begin
        if (en) begin
            p_reg[0]   <= S_W'(p0);
            q_reg[0]   <= '0;
            dlo_reg[0] <= dividend[QUOT_W-1:0];
            s_reg[0]   <= s;
            neg_reg[0] <= neg;
            big_reg[0] <= big0;
        end
    end

    for (genvar j = 1; j < NST; j++) begin : g_step
        logic [S_W:0]      p_sh;
        logic [S_W-1:0]    p_next;
        logic [QUOT_W-1:0] q_next;

        assign p_sh = {p_reg[j-1], dlo_reg[j-1][QUOT_W-1]};

        always_comb begin
            if (p_sh >= {1'b0, s_reg[j-1]}) begin
                p_next = S_W'(p_sh - {1'b0, s_reg[j-1]});
                q_next = {q_reg[j-1][QUOT_W-2:0], 1'b1};
            end else begin
                p_next = p_sh[S_W-1:0];
                q_next = {q_reg[j-1][QUOT_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                p_reg[j]   <= p_next;
                q_reg[j]   <= q_next;
                dlo_reg[j] <= dlo_reg[j-1] << 1;
                s_reg[j]   <= s_reg[j-1];
                neg_reg[j] <= neg_reg[j-1];
                big_reg[j] <= big_reg[j-1];
            end
        end
    end

    always_comb begin
        logic [QUOT_W-1:0] q;
        q = q_reg[NST-1];
        if (neg_reg[NST-1]) begin
            if (big_reg[NST-1] || q > QUOT_W'(Q_MIN)) begin
                q_out = Q_MIN;
            end else begin
                q_out = DATA_W'(-q);
            end
        end else begin
            if (big_reg[NST-1] || q > QUOT_W'(Q_MAX)) begin
                q_out = Q_MAX;
            end else begin
                q_out = q[DATA_W-1:0];
            end
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/rmq_back.sv =====
// Back end: pipelined square root, three dividers and the output register.
`timescale 1ns / 1ps
`default_nettype none
module rmq_back #(
    parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF,
    parameter int RAD_W     = 34
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire rmq_pkg::meta_t            in_meta,
    input  wire logic [RAD_W-1:0]          in_rad,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output logic [4*rmq_pkg::DATA_W-1:0]   out_data,
    output logic [2:0]                     out_user
);
    import rmq_pkg::*;

    localparam int X_W   = RAD_W + FRAC_BITS;
    localparam int SQ_W  = X_W + (X_W % 2);
    localparam int R_W   = SQ_W / 2;
    localparam int REM_W = R_W + 2;
    localparam int SH_W  = REM_W + 2;
    localparam int DIV_L = QUOT_W + 1;
    localparam int PL    = R_W + DIV_L;
    localparam int HW_W  = R_W + DATA_W;

    logic                 en;
    logic [PL-1:0]        valid_reg;
    meta_t                meta_reg [PL];
    logic [REM_W-1:0]     sq_rem_reg  [R_W];
    logic [R_W-1:0]       sq_root_reg [R_W];
    logic [SQ_W-1:0]      sq_x_reg    [R_W];
    logic [DATA_W-1:0]    hr_reg [DIV_L];
    logic [R_W-1:0]       root;
    logic [HW_W-1:0]      half_w;
    logic [DATA_W-1:0]    half_sat;
    logic [DATA_W-1:0]    quo [3];
    logic                 out_valid_reg;
    logic [DATA_W-1:0]    qx_reg, qy_reg, qz_reg, qw_reg;
    logic [DATA_W-1:0]    qx_next, qy_next, qz_next, qw_next;
    branch_t              branch_reg;
    logic                 bad_reg;

    // Whole pipeline moves together; it halts only while the output is held.
    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[PL-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            meta_reg[0] <= in_meta;
            for (int k = 1; k < PL; k++) begin
                meta_reg[k] <= meta_reg[k-1];
            end
        end
    end

    // Digit-by-digit square root of rad * 2^FRAC_BITS, one bit pair per stage.
    for (genvar k = 0; k < R_W; k++) begin : g_sq
        logic [REM_W-1:0] rem_prev, rem_next;
        logic [R_W-1:0]   root_prev, root_next;
        logic [SQ_W-1:0]  x_prev;
        logic [SH_W-1:0]  rem_sh, trial;

        if (k == 0) begin : g_first
            assign rem_prev  = '0;
            assign root_prev = '0;
            assign x_prev    = SQ_W'({in_rad, {FRAC_BITS{1'b0}}});
        end else begin : g_next
            assign rem_prev  = sq_rem_reg[k-1];
            assign root_prev = sq_root_reg[k-1];
            assign x_prev    = sq_x_reg[k-1];
        end

        assign rem_sh = {rem_prev, x_prev[SQ_W-1 -: 2]};
        assign trial  = SH_W'({root_prev, 2'b01});

        always_comb begin
            if (rem_sh >= trial) begin
                rem_next  = REM_W'(rem_sh - trial);
                root_next = {root_prev[R_W-2:0], 1'b1};
            end else begin
                rem_next  = rem_sh[REM_W-1:0];
                root_next = {root_prev[R_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                sq_rem_reg[k]  <= rem_next;
                sq_root_reg[k] <= root_next;
                sq_x_reg[k]    <= x_prev << 2;
            end
        end
    end

    assign root   = sq_root_reg[R_W-1];
    assign half_w = HW_W'(root) >> 1;
    assign half_sat = (half_w > HW_W'(Q_MAX)) ? Q_MAX : half_w[DATA_W-1:0];

    always_ff @(posedge aclk) begin
        if (en) begin
            hr_reg[0] <= half_sat;
            for (int k = 1; k < DIV_L; k++) begin
                hr_reg[k] <= hr_reg[k-1];
            end
        end
    end

    for (genvar i = 0; i < 3; i++) begin : g_div
        rmq_div #(
            .FRAC_BITS (FRAC_BITS),
            .S_W       (R_W + 1)
        ) u_div (
            .aclk  (aclk),
            .en    (en),
            .mag   (meta_reg[R_W-1].num_mag[i]),
            .neg   (meta_reg[R_W-1].num_neg[i]),
            .s     ({root, 1'b0}),
            .q_out (quo[i])
        );
    end

    always_comb begin
        meta_t   m;
        m = meta_reg[PL-1];
        unique case (m.branch)
            BR_TRACE: begin
                qx_next = quo[0]; qy_next = quo[1]; qz_next = quo[2];
                qw_next = hr_reg[DIV_L-1];
            end
            BR_X: begin
                qx_next = hr_reg[DIV_L-1]; qy_next = quo[0]; qz_next = quo[1];
                qw_next = quo[2];
            end
            BR_Y: begin
                qx_next = quo[0]; qy_next = hr_reg[DIV_L-1]; qz_next = quo[1];
                qw_next = quo[2];
            end
            BR_Z: begin
                qx_next = quo[0]; qy_next = quo[1]; qz_next = hr_reg[DIV_L-1];
                qw_next = quo[2];
            end
            default: begin
                qx_next = '0; qy_next = '0; qz_next = '0; qw_next = '0;
            end
        endcase
        if (m.bad) begin
            qx_next = '0; qy_next = '0; qz_next = '0; qw_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (en) begin
            out_valid_reg <= valid_reg[PL-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en && valid_reg[PL-1]) begin
            qx_reg     <= qx_next;
            qy_reg     <= qy_next;
            qz_reg     <= qz_next;
            qw_reg     <= qw_next;
            branch_reg <= meta_reg[PL-1].branch;
            bad_reg    <= meta_reg[PL-1].bad;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = {qw_reg, qz_reg, qy_reg, qx_reg};
    assign out_user  = {bad_reg, branch_reg};

endmodule
`default_nettype wire

// ===== hw/rtl/rotation_matrix_to_quaternion.sv =====
// Top level of the rotation matrix to quaternion converter.
`timescale 1ns / 1ps
`default_nettype none
// Converts a 3x3 rotation matrix (signed fixed point, FRAC_BITS fraction bits) to a
// quaternion by Shepperd's method and takes one matrix per clock when the output side
// keeps up. An accepted item passes the front-end register, which loads on the
// accepting edge, then one queue slot, R root stages, 34 divider stages and the output
// register, where R = ceil((max(FRAC_BITS,33)+1+FRAC_BITS)/2) is the number of
// square-root stages. The three quotients run in parallel dividers after the root.
// A non-positive radicand on a fallback branch yields an all-zero quaternion with the
// invalid flag set. trace_epsilon is written through cfg_*; the user must write it
// only while no item is in flight, as the block itself does not enforce it.
module rotation_matrix_to_quaternion #(
    parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [rmq_pkg::EPS_W-1:0]    cfg_data,    // trace_epsilon
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    // m00, m01, m02, m10, m11, m12, m20, m21, m22 (32 bits each)
    input  wire logic [9*rmq_pkg::DATA_W-1:0] s_tdata,
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    output logic [4*rmq_pkg::DATA_W-1:0]      m_tdata,     // quat_x, quat_y, quat_z, quat_w
    output logic [2:0]                        m_tuser      // branch_taken[1:0], invalid
);
    import rmq_pkg::*;

    localparam int RAD_W = ((FRAC_BITS > 33) ? FRAC_BITS : 33) + 1;
    localparam int Q_W   = $bits(meta_t) + RAD_W;

    logic [EPS_W-1:0] eps_reg;
    logic             f_valid, f_ready, q_valid, q_ready;
    meta_t            f_meta, q_meta;
    logic [RAD_W-1:0] f_rad, q_rad;
    logic [Q_W-1:0]   q_data;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            eps_reg <= EPS_RESET;
        end else if (cfg_valid) begin
            eps_reg <= cfg_data;
        end
    end

    rmq_front #(
        .FRAC_BITS (FRAC_BITS),
        .RAD_W     (RAD_W)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .epsilon   (eps_reg),
        .out_valid (f_valid),
        .out_ready (f_ready),
        .out_meta  (f_meta),
        .out_rad   (f_rad)
    );

    rmq_fifo #(
        .WIDTH (Q_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_data   ({f_meta, f_rad}),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_data  (q_data)
    );

    assign {q_meta, q_rad} = q_data;

    rmq_back #(
        .FRAC_BITS (FRAC_BITS),
        .RAD_W     (RAD_W)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (q_valid),
        .in_ready  (q_ready),
        .in_meta   (q_meta),
        .in_rad    (q_rad),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata),
        .out_user  (m_tuser)
    );

endmodule
`default_nettype wire

// ===== hw/rtl/rmq_checker.sv =====
// Port-level checks on the result stream, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module rmq_checker (
    input wire logic                         aclk,
    input wire logic                         aresetn,
    input wire logic                         m_tvalid,
    input wire logic                         m_tready,
    input wire logic [4*rmq_pkg::DATA_W-1:0] m_tdata,
    input wire logic [2:0]                   m_tuser
);
    import rmq_pkg::*;

    a_valid_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result valid dropped while stalled");

    a_data_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // Invalid results carry an all-zero quaternion.
    a_invalid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[2] |-> m_tdata == '0)
        else $error("invalid item with nonzero quaternion");

    // The trace branch always has a positive radicand.
    a_invalid_branch: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[2] |-> m_tuser[1:0] != BR_TRACE)
        else $error("invalid flag on trace branch");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

endmodule

bind rotation_matrix_to_quaternion rmq_checker u_rmq_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
`default_nettype wire

// ===== bench/rotation_matrix_to_quaternion_test.sv =====
// Self-checking bench for the rotation matrix to quaternion converter.
`timescale 1ns / 1ps
module rotation_matrix_to_quaternion_test;
    import rmq_pkg::*;

    localparam int FB = 30;
    localparam int LAT = 80;
    localparam longint CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [31:0] x, y, z, w;
        branch_t     br;
        logic        bad;
    } quat_t;

    logic aclk = 0, aresetn = 0;
    logic cfg_valid = 0;
    logic [EPS_W-1:0] cfg_data = '0;
    logic cfg_ready;
    logic s_tvalid = 0;
    logic [9*DATA_W-1:0] s_tdata = '0;
    logic s_tready;
    logic m_tvalid;
    logic m_tready = 0;
    logic [4*DATA_W-1:0] m_tdata;
    logic [2:0] m_tuser;

    rotation_matrix_to_quaternion i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    always #1 aclk = ~aclk;

    longint unsigned eps = EPS_RESET;
    quat_t pending_quats[$];
    int errors = 0;
    longint cycles = 0;
    bit sink_busy = 1;   // sink stalls randomly while set

    function automatic logic [127:0] isqrt_scaled(input longint unsigned rad);
        logic [127:0] v, rem, root, trial;
        v = {64'd0, rad} << FB;
        rem = 0;
        root = 0;
        for (int i = 63; i >= 0; i--) begin
            rem = (rem << 2) | ((v >> (2 * i)) & 3);
            trial = (root << 2) | 1;
            if (rem >= trial) begin
                rem -= trial;
                root = (root << 1) | 1;
            end else begin
                root = root << 1;
            end
        end
        return root;
    endfunction

    function automatic logic [31:0] div_sat(input longint num, input logic [127:0] den);
        logic [127:0] mag, q;
        mag = (num < 0) ? 128'(-num) : 128'(num);
        q = (mag << FB) / den;
        if (num < 0) return (q > 128'h8000_0000) ? Q_MIN : 32'(-q);
        return (q > 128'h7FFF_FFFF) ? Q_MAX : q[31:0];
    endfunction

    function automatic logic [31:0] half_sat(input logic [127:0] r);
        return ((r >> 1) > 128'h7FFF_FFFF) ? Q_MAX : 32'(r >> 1);
    endfunction

    function automatic quat_t predict_quat(input logic [9*DATA_W-1:0] d);
        longint a[9];
        longint one, t, rad;
        logic [127:0] r, s;
        quat_t q;
        for (int i = 0; i < 9; i++) a[i] = longint'($signed(d[32*i +: 32]));
        one = longint'(1) << FB;
        t = one + a[0] + a[4] + a[8];
        q = '0;
        if (t > longint'(eps)) begin
            q.br = BR_TRACE; rad = t;
        end else if (a[0] > a[4] && a[0] > a[8]) begin
            q.br = BR_X; rad = one + a[0] - a[4] - a[8];
        end else if (a[4] > a[8]) begin
            q.br = BR_Y; rad = one + a[4] - a[0] - a[8];
        end else begin
            q.br = BR_Z; rad = one + a[8] - a[0] - a[4];
        end
        if (rad <= 0) begin
            q.bad = 1;
            return q;
        end
        r = isqrt_scaled(longint'(rad));
        s = r << 1;
        if (s == 0) begin
            q.bad = 1;
            return q;
        end
        case (q.br)
            BR_TRACE: begin
                q.x = div_sat(a[5] - a[7], s); q.y = div_sat(a[6] - a[2], s);
                q.z = div_sat(a[1] - a[3], s); q.w = half_sat(r);
            end
            BR_X: begin
                q.x = half_sat(r); q.y = div_sat(a[1] + a[3], s);
                q.z = div_sat(a[6] + a[2], s); q.w = div_sat(a[5] - a[7], s);
            end
            BR_Y: begin
                q.x = div_sat(a[1] + a[3], s); q.y = half_sat(r);
                q.z = div_sat(a[5] + a[7], s); q.w = div_sat(a[6] - a[2], s);
            end
            default: begin
                q.x = div_sat(a[6] + a[2], s); q.y = div_sat(a[5] + a[7], s);
                q.z = half_sat(r); q.w = div_sat(a[1] - a[3], s);
            end
        endcase
        return q;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h want %h", what, got, want);
        errors++;
    endtask

    // output check and cycle limit
    always @(posedge aclk) begin
        quat_t exp_q;
        cycles++;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_quats.size() == 0) begin
                report_mismatch("unexpected item", m_tdata[31:0], 32'd0);
            end else begin
                exp_q = pending_quats.pop_front();
                if (m_tdata[31:0] !== exp_q.x) report_mismatch("quat_x", m_tdata[31:0], exp_q.x);
                if (m_tdata[63:32] !== exp_q.y) report_mismatch("quat_y", m_tdata[63:32], exp_q.y);
                if (m_tdata[95:64] !== exp_q.z) report_mismatch("quat_z", m_tdata[95:64], exp_q.z);
                if (m_tdata[127:96] !== exp_q.w)
                    report_mismatch("quat_w", m_tdata[127:96], exp_q.w);
                if (m_tuser[1:0] !== exp_q.br)
                    report_mismatch("branch", 32'(m_tuser[1:0]), 32'(exp_q.br));
                if (m_tuser[2] !== exp_q.bad)
                    report_mismatch("invalid", 32'(m_tuser[2]), 32'(exp_q.bad));
            end
        end
        if (cycles > CYCLE_LIMIT) begin
            $display("rotation_matrix_to_quaternion_test: done, errors");
            $finish;
        end
    end

    always @(negedge aclk) m_tready <= sink_busy ? ($urandom_range(99) >= 30) : 1'b1;

    task automatic write_eps(input logic [EPS_W-1:0] v);
        cfg_valid <= 1;
        cfg_data <= v;
        do @(posedge aclk); while (!cfg_ready);
        eps = v;
        @(negedge aclk);
        cfg_valid <= 0;
    endtask

    task automatic drain();
        while (pending_quats.size() != 0) @(negedge aclk);
        repeat (LAT) @(negedge aclk);
    endtask

    // one item; idle gaps are drawn before it when gaps are on
    task automatic send_matrix(input logic [9*DATA_W-1:0] d, input bit gaps);
        if (gaps)
            while ($urandom_range(99) < 30) begin
                s_tvalid <= 0;
                @(negedge aclk);
            end
        s_tvalid <= 1;
        s_tdata <= d;
        do @(posedge aclk); while (!s_tready);
        pending_quats.push_back(predict_quat(d));
        @(negedge aclk);
    endtask

    function automatic logic [9*DATA_W-1:0] pack9(input int unsigned e[9]);
        logic [9*DATA_W-1:0] d;
        for (int i = 0; i < 9; i++) d[32*i +: 32] = e[i];
        return d;
    endfunction

    function automatic logic [31:0] rand_entry(input bit wide);
        if (wide) return $urandom;
        return 32'($signed($urandom_range(32'h8000_0000)) - 32'sh4000_0000);
    endfunction

    localparam int unsigned ONE = 32'h4000_0000;
    localparam int unsigned NEG1 = 32'hC000_0000;
    localparam int unsigned MAXV = 32'h7FFF_FFFF;
    localparam int unsigned MINV = 32'h8000_0000;

    typedef struct {
        int unsigned m[9];
        bit          known;
        quat_t       q;
    } stim_row_t;

    stim_row_t dir_rows[] = '{
        // identity: w = 1, rest zero
        '{'{ONE, 0, 0, 0, ONE, 0, 0, 0, ONE}, 1, '{0, 0, 0, ONE, BR_TRACE, 0}},
        // 180 deg about x
        '{'{ONE, 0, 0, 0, NEG1, 0, 0, 0, NEG1}, 1, '{ONE, 0, 0, 0, BR_X, 0}},
        '{'{NEG1, 0, 0, 0, ONE, 0, 0, 0, NEG1}, 1, '{0, ONE, 0, 0, BR_Y, 0}},
        '{'{NEG1, 0, 0, 0, NEG1, 0, 0, 0, ONE}, 1, '{0, 0, ONE, 0, BR_Z, 0}},
        // all-zero matrix: trace branch with t = 1
        '{'{0, 0, 0, 0, 0, 0, 0, 0, 0}, 1, '{0, 0, 0, 32'h2000_0000, BR_TRACE, 0}},
        // ties on the diagonal
        '{'{NEG1, 0, 0, 0, NEG1, 0, 0, 0, NEG1}, 0, '0},
        '{'{32'hE000_0000, 0, 0, 0, 32'hE000_0000, 0, 0, 0, NEG1}, 0, '0},
        '{'{32'hE000_0000, 5, 7, 9, NEG1, 3, 2, 1, 32'hE000_0000}, 0, '0},
        // extreme diagonals: all-minimum (fallback), and m00 = -1 with maximal m11, m22 (trace)
        '{'{MINV, 1, 2, 3, MINV, 4, 5, 6, MINV}, 0, '0},
        '{'{NEG1, 0, 0, 0, MAXV, 0, 0, 0, MAXV}, 0, '0},
        // extreme entries; the last row saturates its quotients
        '{'{MAXV, MAXV, MINV, MINV, MINV, MAXV, MAXV, MINV, MINV}, 0, '0},
        '{'{MINV, MINV, MAXV, MAXV, MINV, MINV, MINV, MAXV, MINV}, 0, '0},
        '{'{MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV}, 0, '0},
        '{'{MINV, MAXV, MAXV, MAXV, MINV, MAXV, MAXV, MAXV, NEG1}, 0, '0},
        '{'{32'hFFFF_FFFF, MINV, MAXV, MAXV, 32'hFFFF_FFFF, MINV, MINV, MAXV, 32'hFFFF_FFFF},
          0, '0}
    };

    initial begin
        int unsigned e[9];
        int mode;
        repeat (3) @(negedge aclk);
        aresetn = 1;
        @(negedge aclk);

        foreach (dir_rows[i]) begin
            send_matrix(pack9(dir_rows[i].m), 1);
            if (dir_rows[i].known) begin
                pending_quats.pop_back();
                pending_quats.push_back(dir_rows[i].q);
            end
        end
        s_tvalid <= 0;
        drain();

        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: write_eps('0);
                1: write_eps(31'h4000_0000);
                2: write_eps(EPS_RESET);
                3: write_eps($urandom_range(32'h4000_0000));
                default: write_eps(31'h7FFF_FFFF);
            endcase
            sink_busy = (ph != 2);
            for (int n = 0; n < 160; n++) begin
                mode = $urandom_range(9);
                for (int i = 0; i < 9; i++) e[i] = rand_entry(mode == 0);
                // push traces near zero so fallback branches are reached
                if (mode >= 6) begin
                    e[0] = 32'($signed(NEG1) + $signed($urandom_range(32'h3000_0000)));
                    e[4] = 32'($signed(NEG1) + $signed($urandom_range(32'h3000_0000)));
                    e[8] = 32'($signed(NEG1) + $signed($urandom_range(32'h3000_0000)));
                    if (mode == 9) e[4] = e[0];
                end
                send_matrix(pack9(e), ph != 2);
                if (n == 80) begin
                    s_tvalid <= 0;
                    while (pending_quats.size() != 0) @(negedge aclk);
                end
            end
            s_tvalid <= 0;
            drain();
        end

        if (errors == 0) begin
            $display("rotation_matrix_to_quaternion_test: done, clean");
        end else begin
            $display("rotation_matrix_to_quaternion_test: done, errors");
        end
        $finish;
    end
endmodule

// ===== sim.f =====
hw/rtl/rmq_pkg.sv
hw/rtl/rmq_front.sv
hw/rtl/rmq_fifo.sv
hw/rtl/rmq_div.sv
hw/rtl/rmq_back.sv
hw/rtl/rotation_matrix_to_quaternion.sv
hw/rtl/rmq_checker.sv
bench/rotation_matrix_to_quaternion_test.sv
